@@ rtl/mprt_pkg.sv @@
// Shared types and constants for the merging priority request table.
// Used by mprt_cell, mprt_scorer and merging_priority_request_table_core.
// Depends on nothing.
`default_nettype none

package mprt_pkg;

    localparam int NUM_REGS      = 4;
    localparam int COST_CLASSES  = 4;
    localparam int CLS_TOP       = (COST_CLASSES < NUM_REGS ? COST_CLASSES : NUM_REGS) - 1;
    localparam int CLASS_COST_W  = 24;
    localparam int SCORE_W       = 22;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 22'h3FFFFF;

    localparam logic [CLASS_COST_W-1:0] CLASS0_RESET = 24'd1000;
    localparam logic [CLASS_COST_W-1:0] CLASS1_RESET = 24'd4000;
    localparam logic [CLASS_COST_W-1:0] CLASS2_RESET = 24'd16000;
    localparam logic [CLASS_COST_W-1:0] CLASS3_RESET = 24'd40000;

    localparam logic [1:0] OP_SUBMIT  = 2'd0;
    localparam logic [1:0] OP_COMPACT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    typedef logic [NUM_REGS-1:0][CLASS_COST_W-1:0] t_class_cost;

    typedef struct packed {
        logic [63:0]        key;
        logic [16:0]        imp;
        logic [16:0]        cov;
        logic [16:0]        conf;
        logic [7:0]         deficit;
        logic [31:0]        time_us;
        logic [15:0]        wait_ms;
        logic [23:0]        meas;
        logic [1:0]         cls;
        logic [31:0]        bytes;
        logic               guar;
        logic [15:0]        subs;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_MERGE,
        CELL_FROM_UP,
        CELL_FROM_DOWN,
        CELL_FROM_HEAD
    } t_cell_op;

endpackage

`default_nettype wire

@@ rtl/mprt_cell.sv @@
// One slot of the request table: holds an entry, merges requests into it,
// and trades its entry with its neighbors for rotation and sorting. Uses mprt_pkg.
`default_nettype none

module mprt_cell (
    input  wire logic              i_clk,
    input  wire mprt_pkg::t_cell_op i_op,
    input  wire logic              i_live,
    input  wire mprt_pkg::t_entry  i_req,
    input  wire mprt_pkg::t_entry  i_up,
    input  wire mprt_pkg::t_entry  i_down,
    input  wire mprt_pkg::t_entry  i_head,
    output mprt_pkg::t_entry       o_rec,
    output logic                   o_match,
    output logic                   o_beats_down
);
    import mprt_pkg::*;

    t_entry r_rec;
    t_entry n_rec;

    always_comb begin
        n_rec = r_rec;
        case (i_op)
            CELL_HOLD: ;
            CELL_LOAD: n_rec = i_req;
            CELL_MERGE: begin
                n_rec.imp     = (i_req.imp > r_rec.imp) ? i_req.imp : r_rec.imp;
                n_rec.cov     = (i_req.cov > r_rec.cov) ? i_req.cov : r_rec.cov;
                n_rec.conf    = (i_req.conf > r_rec.conf) ? i_req.conf : r_rec.conf;
                n_rec.deficit = (i_req.deficit > r_rec.deficit) ? i_req.deficit
                                                                : r_rec.deficit;
                n_rec.time_us = (i_req.time_us < r_rec.time_us) ? i_req.time_us
                                                                : r_rec.time_us;
                n_rec.wait_ms = (i_req.wait_ms > r_rec.wait_ms) ? i_req.wait_ms
                                                                : r_rec.wait_ms;
                n_rec.meas    = (i_req.meas > r_rec.meas) ? i_req.meas : r_rec.meas;
                n_rec.cls     = (i_req.cls > r_rec.cls) ? i_req.cls : r_rec.cls;
                n_rec.bytes   = (i_req.bytes > r_rec.bytes) ? i_req.bytes : r_rec.bytes;
                n_rec.guar    = r_rec.guar | i_req.guar;
                n_rec.subs    = (r_rec.subs != 16'hFFFF) ? r_rec.subs + 16'd1 : r_rec.subs;
            end
            CELL_FROM_UP:   n_rec = i_up;
            CELL_FROM_DOWN: n_rec = i_down;
            CELL_FROM_HEAD: n_rec = i_head;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec   = r_rec;
    assign o_match = i_live && (r_rec.key == i_req.key);
    // Higher score first; equal scores fall back to the smaller key.
    assign o_beats_down = (r_rec.score > i_down.score) ||
                          ((r_rec.score == i_down.score) && (r_rec.key < i_down.key));

endmodule

`default_nettype wire

@@ rtl/mprt_scorer.sv @@
// Iterative score unit: square root and urgency division one bit per cycle,
// then a short multiply pipeline. Uses mprt_pkg.
`default_nettype none

module mprt_scorer (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire mprt_pkg::t_entry         i_rec,
    input  wire mprt_pkg::t_class_cost    i_cost,
    output logic                          o_idle,
    output logic                          o_done,
    output logic [mprt_pkg::SCORE_W-1:0]  o_score
);
    import mprt_pkg::*;

    typedef enum logic [2:0] {SC_IDLE, SC_ITER, SC_S0, SC_S1, SC_S2, SC_S3, SC_DONE} t_sc_state;

    localparam logic [38:0] URG_NUM    = 39'd458752000000;
    localparam logic [5:0]  DIV_LAST   = 6'd38;
    localparam logic [5:0]  SQRT_STEPS = 6'd17;
    localparam logic [15:0] DEM_W_IMP  = 16'd39322;
    localparam logic [15:0] DEM_W_COV  = 16'd26214;
    localparam logic [15:0] CONF_W     = 16'd49152;
    localparam logic [26:0] AGE_RECIP  = 27'd109951163;

    t_sc_state    r_state;
    logic [5:0]   r_cnt;
    logic [16:0]  r_imp, r_conf;
    logic [32:0]  r_sv, r_sr, r_sbit;
    logic [33:0]  r_div_d, r_rem;
    logic [18:0]  r_q;
    logic         r_nodl, r_late;
    logic [3:0]   r_gain2;
    logic [11:0]  r_wait_c;
    logic [16:0]  r_demand, r_confq, r_age;
    logic [19:0]  r_urg;
    logic [25:0]  r_agex;
    logic [20:0]  r_p1;
    logic [36:0]  r_p2;
    logic [39:0]  r_mlo;
    logic [38:0]  r_mhi;
    logic [SCORE_W-1:0] r_score;

    logic [1:0]   w_cls;
    logic [23:0]  w_cost;
    logic [31:0]  w_diff;
    logic [34:0]  w_rem_sh;
    logic [33:0]  w_sq_sum;
    logic [33:0]  w_dem_sum;
    logic [32:0]  w_cf;
    logic [52:0]  w_agem;
    logic [57:0]  w_prod;
    logic [25:0]  w_sum;

    always_comb begin
        w_cls    = (i_rec.cls > 2'(CLS_TOP)) ? 2'(CLS_TOP) : i_rec.cls;
        w_cost   = (i_rec.meas != 24'd0) ? i_rec.meas : i_cost[w_cls];
        w_diff   = i_rec.time_us - {8'd0, w_cost};
        w_rem_sh = {r_rem, URG_NUM[DIV_LAST - r_cnt]};
        w_sq_sum = {1'b0, r_sr} + {1'b0, r_sbit};
        w_dem_sum = 34'(DEM_W_IMP) * 34'(r_imp) + 34'(DEM_W_COV) * 34'(r_sr[16:0]);
        w_cf     = 33'(CONF_W) * 33'(r_conf);
        w_agem   = 53'(r_agex) * 53'(AGE_RECIP);
        w_prod   = {r_mhi, 19'd0} + 58'(r_mlo);
        w_sum    = 26'(w_prod[57:33]) + 26'(r_age);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_imp    <= (i_rec.imp > 17'd65536) ? 17'd65536 : i_rec.imp;
                        r_conf   <= (i_rec.conf > 17'd65536) ? 17'd65536 : i_rec.conf;
                        r_sv     <= {((i_rec.cov > 17'd65536) ? 17'd65536 : i_rec.cov), 16'd0};
                        r_sr     <= '0;
                        r_sbit   <= 33'h1_0000_0000;
                        r_gain2  <= 4'd2 + ((i_rec.deficit > 8'd8) ? 4'd8 : i_rec.deficit[3:0]);
                        r_wait_c <= (i_rec.wait_ms > 16'd4000) ? 12'd4000 : i_rec.wait_ms[11:0];
                        r_nodl   <= (i_rec.time_us == 32'hFFFF_FFFF);
                        r_late   <= (i_rec.time_us <= {8'd0, w_cost});
                        r_div_d  <= 34'd1000000 + {1'b0, w_diff, 1'b0};
                        r_rem    <= '0;
                        r_q      <= '0;
                        r_cnt    <= '0;
                        r_state  <= SC_ITER;
                    end
                end
                SC_ITER: begin
                    if (w_rem_sh >= {1'b0, r_div_d}) begin
                        r_rem <= 34'(w_rem_sh - {1'b0, r_div_d});
                        r_q   <= {r_q[17:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh[33:0];
                        r_q   <= {r_q[17:0], 1'b0};
                    end
                    if (r_cnt < SQRT_STEPS) begin
                        if ({1'b0, r_sv} >= w_sq_sum) begin
                            r_sv <= 33'({1'b0, r_sv} - w_sq_sum);
                            r_sr <= (r_sr >> 1) + r_sbit;
                        end else begin
                            r_sr <= r_sr >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= SC_S0;
                    end
                end
                SC_S0: begin
                    r_demand <= w_dem_sum[32:16];
                    r_urg    <= r_nodl ? 20'd65536 :
                                r_late ? 20'd524288 : 20'd65536 + 20'(r_q);
                    r_confq  <= 17'd16384 + w_cf[32:16];
                    r_agex   <= 26'(r_wait_c) * 26'd14336;
                    r_state  <= SC_S1;
                end
                SC_S1: begin
                    r_p1    <= 21'(r_demand) * 21'(r_gain2);
                    r_p2    <= 37'(r_urg) * 37'(r_confq);
                    r_age   <= w_agem[52:36];
                    r_state <= SC_S2;
                end
                SC_S2: begin
                    r_mlo   <= 40'(r_p1) * 40'(r_p2[18:0]);
                    r_mhi   <= 39'(r_p1) * 39'(r_p2[36:19]);
                    r_state <= SC_S3;
                end
                SC_S3: begin
                    r_score <= (w_sum > 26'(SCORE_MAX)) ? SCORE_MAX : w_sum[SCORE_W-1:0];
                    r_state <= SC_DONE;
                end
                SC_DONE: r_state <= SC_IDLE;
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_idle  = (r_state == SC_IDLE);
    assign o_done  = (r_state == SC_DONE);
    assign o_score = r_score;

endmodule

`default_nettype wire

@@ rtl/merging_priority_request_table_core.sv @@
// Merging priority request table: a row of entry cells, a shared score unit and control.
// Submit, clear and idle ops give their one result beat the cycle after the input beat.
// Compact scores each entry in turn in the score unit (39-step division),
// then runs odd-even sorting in the cell row, then gives one beat per entry.
// Short ops can follow every cycle while results are taken. Synchronous active-low reset
// empties the table and restores the class cost registers; entry contents are not cleared.
`default_nettype none

module merging_priority_request_table_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [23:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // key[63:0] importance[80:64] coverage[97:81] mip_shortfall[105:98]
    // confidence[122:106] time_needed_us[154:123] wait_ms[170:155]
    // measured_cost_us[194:171] cost_class[196:195] byte_count[228:197] guaranteed[229]
    input  wire logic [231:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_key[63:0] score[85:64] out_bytes[117:86] out_guaranteed[118]
    // submission_count[134:119]
    output logic [135:0]      m_axis_tdata,
    // status[0] empty_res[1]
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import mprt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [1:0] USER_FULL  = 2'b01;
    localparam logic [1:0] USER_EMPTY = 2'b10;

    typedef enum logic [1:0] {ST_IDLE, ST_SCORE, ST_SORT, ST_EMIT} t_state;

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count, r_idx, n_idx, r_round, n_round;
    logic        r_out_valid, n_out_valid, r_out_last, n_out_last;
    logic [135:0] r_out_data, n_out_data;
    logic [1:0]  r_out_user, n_out_user;
    t_class_cost r_class_cost;

    t_entry      w_req, w_head;
    t_entry      w_rec [TABLE_ENTRIES];
    t_cell_op    w_op  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_match, w_beats;
    logic        w_in_acc, w_out_free, w_any_match;
    logic [CNT_W-1:0] w_last_idx;
    logic        w_scr_start, w_scr_idle, w_scr_done;
    logic [SCORE_W-1:0] w_scr_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_cost[0] <= CLASS0_RESET;
            r_class_cost[1] <= CLASS1_RESET;
            r_class_cost[2] <= CLASS2_RESET;
            r_class_cost[3] <= CLASS3_RESET;
        end else if (i_cfg_we) begin
            r_class_cost[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_comb begin
        w_req.key     = s_axis_tdata[63:0];
        w_req.imp     = s_axis_tdata[80:64];
        w_req.cov     = s_axis_tdata[97:81];
        w_req.deficit = s_axis_tdata[105:98];
        w_req.conf    = s_axis_tdata[122:106];
        w_req.time_us = s_axis_tdata[154:123];
        w_req.wait_ms = s_axis_tdata[170:155];
        w_req.meas    = s_axis_tdata[194:171];
        w_req.cls     = s_axis_tdata[196:195];
        w_req.bytes   = s_axis_tdata[228:197];
        w_req.guar    = s_axis_tdata[229];
        w_req.subs    = 16'd1;
        w_req.score   = '0;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        t_entry w_up, w_down;
        if (g < TABLE_ENTRIES - 1) begin : g_up
            assign w_up = w_rec[g+1];
        end else begin : g_top
            assign w_up = w_rec[g];
        end
        if (g > 0) begin : g_down
            assign w_down = w_rec[g-1];
        end else begin : g_bottom
            assign w_down = w_rec[g];
        end
        mprt_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op[g]),
            .i_live       (CNT_W'(g) < r_count),
            .i_req        (w_req),
            .i_up         (w_up),
            .i_down       (w_down),
            .i_head       (w_head),
            .o_rec        (w_rec[g]),
            .o_match      (w_match[g]),
            .o_beats_down (w_beats[g])
        );
    end

    mprt_scorer u_scorer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scr_start),
        .i_rec   (w_rec[0]),
        .i_cost  (r_class_cost),
        .o_idle  (w_scr_idle),
        .o_done  (w_scr_done),
        .o_score (w_scr_score)
    );

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_any_match   = |w_match;
    assign w_last_idx    = r_count - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_round     = r_round;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        w_head      = w_rec[0];
        w_scr_start = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            w_op[i] = CELL_HOLD;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_user  = USER_EMPTY;
                    n_out_last  = 1'b1;
                    case (s_axis_tuser)
                        OP_SUBMIT: begin
                            if (w_any_match) begin
                                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                    if (w_match[i]) w_op[i] = CELL_MERGE;
                                end
                            end else if (r_count < CNT_W'(TABLE_ENTRIES)) begin
                                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                                    if (CNT_W'(i) == r_count) w_op[i] = CELL_LOAD;
                                end
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_out_user = USER_EMPTY | USER_FULL;
                            end
                        end
                        OP_COMPACT: begin
                            if (r_count != '0) begin
                                n_out_valid = r_out_valid && !m_axis_tready;
                                n_state     = ST_SCORE;
                                n_idx       = '0;
                            end
                        end
                        OP_CLEAR: n_count = '0;
                        default: ;
                    endcase
                end
            end
            ST_SCORE: begin
                w_scr_start = w_scr_idle;
                if (w_scr_done) begin
                    // The scored head entry moves to the back of the live part of the row.
                    w_head.score = w_scr_score;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (CNT_W'(i) < w_last_idx) w_op[i] = CELL_FROM_UP;
                        else if (CNT_W'(i) == w_last_idx) w_op[i] = CELL_FROM_HEAD;
                    end
                    if (r_idx == w_last_idx) begin
                        n_state = ST_SORT;
                        n_round = '0;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            ST_SORT: begin
                // Odd-even transposition: pairs alternate between even and odd lower cells.
                for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
                    if (((i % 2) == 1) == r_round[0] && CNT_W'(i + 1) < r_count
                            && w_beats[i+1]) begin
                        w_op[i]   = CELL_FROM_UP;
                        w_op[i+1] = CELL_FROM_DOWN;
                    end
                end
                n_round = r_round + CNT_W'(1);
                if (r_round == CNT_W'(TABLE_ENTRIES - 1)) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, w_rec[0].subs, w_rec[0].guar, w_rec[0].bytes,
                                   w_rec[0].score, w_rec[0].key};
                    n_out_user  = '0;
                    n_out_last  = (r_idx == w_last_idx);
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (CNT_W'(i) < w_last_idx) w_op[i] = CELL_FROM_UP;
                        else if (CNT_W'(i) == w_last_idx) w_op[i] = CELL_FROM_HEAD;
                    end
                    if (r_idx == w_last_idx) n_state = ST_IDLE;
                    else n_idx = r_idx + CNT_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid |-> $onehot0(w_match))
        else $error("more than one table entry matches the request key");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_count != '0))
        else $error("compact running on an empty table");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free && r_idx == w_last_idx)
            |=> (r_state == ST_IDLE && m_axis_tvalid && m_axis_tlast))
        else $error("final compact beat not marked last");

endmodule

`default_nettype wire
